### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 shared definitions
// S-box tables, round constant steps and GF(2^8) helpers for the round cells.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int RoundCount = 10;
	localparam logic [7:0] GfPoly = 8'h1b;
	localparam logic [7:0] GfTop = 8'h80;

	typedef logic [127:0] blk_t;
	typedef logic [7:0] byte_t;

	// flow control carried from cell to cell
	typedef struct packed {
		logic vld;
		logic dir;
	} cell_ctl_t;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t ISBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// round constants, first round first
	localparam byte_t RCON [10] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic byte_t xtime(input byte_t a);
		xtime = (a & GfTop) != 8'h00 ? ((a << 1) ^ GfPoly) : (a << 1);
	endfunction

	// byte n of a block sits at bits 127-8n
	function automatic byte_t blk_byte(input blk_t b, input int n);
		blk_byte = b[127 - 8 * n -: 8];
	endfunction

endpackage

### rtl/aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Fully unrolled chain of round cells, one block accepted per cycle.
// ----------------------------------------------------------------------------
// Use: drive text_hi/lo and key_hi/lo with start high; a beat is taken at any
// edge where start is high and busy is low. busy is tied low: the chain of
// round cells takes a new block every cycle.
// direction (cfg channel, always ready) selects encrypt (0) with the cipher
// key or decrypt (1) with the last round key; write it only while idle.
// Path: the input key-add register, then one register in each of the
// ROUND_COUNT = 10 round cells, eleven registers in all; done and the result
// come straight from the last cell's register. Throughput one block per
// cycle, set by the eleven-register cell chain.
// done is high for one cycle with result_hi/lo; the receiver cannot stall.
// Reset clears the valid bits in the chain and sets direction to encrypt.
// ----------------------------------------------------------------------------
module aes128_block_cipher #(
	parameter int ROUND_COUNT = aes_pkg::RoundCount
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] text_hi,
	input  logic [63:0] text_lo,
	input  logic [63:0] key_hi,
	input  logic [63:0] key_lo,
	output logic        done,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import aes_pkg::*;

	logic direction_q;
	cell_ctl_t ctl [ROUND_COUNT + 1];
	blk_t st [ROUND_COUNT + 1];
	blk_t ky [ROUND_COUNT + 1];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (cfg_valid) begin
			direction_q <= cfg_data;
		end
	end

	// entry stage: initial key add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl[0] <= '0;
		end else begin
			ctl[0] <= '{vld: start, dir: direction_q};
		end
	end

	always_ff @(posedge clk) begin
		st[0] <= {text_hi, text_lo} ^ {key_hi, key_lo};
		ky[0] <= {key_hi, key_lo};
	end

	// round cells
	for (genvar g = 1; g <= ROUND_COUNT; g++) begin : g_cell
		aes_round_cell #(.RoundIdx(g), .Rounds(ROUND_COUNT)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl[g - 1]),
			.state_in (st[g - 1]),
			.key_in   (ky[g - 1]),
			.ctl_out  (ctl[g]),
			.state_out(st[g]),
			.key_out  (ky[g])
		);
	end

	assign done = ctl[ROUND_COUNT].vld;
	assign result_hi = st[ROUND_COUNT][127:64];
	assign result_lo = st[ROUND_COUNT][63:0];

endmodule

### rtl/aes_round_cell.sv
// ----------------------------------------------------------------------------
// AES round cell
// One round of encryption or decryption with its round key step, registered.
// ----------------------------------------------------------------------------
module aes_round_cell #(
	parameter int RoundIdx = 1,
	parameter int Rounds = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  aes_pkg::cell_ctl_t ctl_in,
	input  aes_pkg::blk_t      state_in,
	input  aes_pkg::blk_t      key_in,
	output aes_pkg::cell_ctl_t ctl_out,
	output aes_pkg::blk_t      state_out,
	output aes_pkg::blk_t      key_out
);
	import aes_pkg::*;

	localparam bit LastRound = (RoundIdx == Rounds);
	// encrypt key step uses rcon of this round; decrypt step undoes round Rounds+1-RoundIdx
	localparam int EncRc = (RoundIdx - 1) % 10;
	localparam int DecRc = (Rounds - RoundIdx) % 10;

	blk_t key_nx, st_nx, t_sb, t_sr, t_mc, t_ak, t_isr, t_isb;
	logic [31:0] w0, w1, w2, w3, n0, n1, n2, n3, sub_w;
	byte_t a0, a1, a2, a3, m0, m1, m2, m3;
	byte_t x2a, x2b, x2c, x2d, x4a, x4b, x4c, x4d, x8a, x8b, x8c, x8d;
	int src;

	// key schedule step, forward or backward
	always_comb begin
		w0 = key_in[127:96];
		w1 = key_in[95:64];
		w2 = key_in[63:32];
		w3 = key_in[31:0];
		if (!ctl_in.dir) begin
			sub_w = {SBOX[w3[23:16]] ^ RCON[EncRc], SBOX[w3[15:8]], SBOX[w3[7:0]],
				SBOX[w3[31:24]]};
			n0 = w0 ^ sub_w;
			n1 = w1 ^ n0;
			n2 = w2 ^ n1;
			n3 = w3 ^ n2;
		end else begin
			n3 = w3 ^ w2;
			n2 = w2 ^ w1;
			n1 = w1 ^ w0;
			sub_w = {SBOX[n3[23:16]] ^ RCON[DecRc], SBOX[n3[15:8]], SBOX[n3[7:0]],
				SBOX[n3[31:24]]};
			n0 = w0 ^ sub_w;
		end
		key_nx = {n0, n1, n2, n3};
	end

	// round datapath
	always_comb begin
		t_sb = '0;
		t_sr = '0;
		t_mc = '0;
		t_isr = '0;
		t_isb = '0;
		t_ak = '0;
		st_nx = '0;
		a0 = '0;
		a1 = '0;
		a2 = '0;
		a3 = '0;
		m0 = '0;
		m1 = '0;
		m2 = '0;
		m3 = '0;
		x2a = '0;
		x2b = '0;
		x2c = '0;
		x2d = '0;
		x4a = '0;
		x4b = '0;
		x4c = '0;
		x4d = '0;
		x8a = '0;
		x8b = '0;
		x8c = '0;
		x8d = '0;
		src = 0;
		if (!ctl_in.dir) begin
			for (int j = 0; j < 16; j++) t_sb[127 - 8 * j -: 8] = SBOX[blk_byte(state_in, j)];
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t_sr[127 - 8 * (4 * c + r) -: 8] = blk_byte(t_sb, 4 * ((c + r) & 3) + r);
			t_mc = t_sr;
			if (!LastRound) begin
				for (int c = 0; c < 4; c++) begin
					a0 = blk_byte(t_sr, 4 * c);
					a1 = blk_byte(t_sr, 4 * c + 1);
					a2 = blk_byte(t_sr, 4 * c + 2);
					a3 = blk_byte(t_sr, 4 * c + 3);
					m0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
					m1 = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
					m2 = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
					m3 = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
					t_mc[127 - 32 * c -: 32] = {m0, m1, m2, m3};
				end
			end
			st_nx = t_mc ^ key_nx;
		end else begin
			// state already carries this round's key; key_nx is the previous round key
			t_ak = state_in;
			t_mc = t_ak;
			if (RoundIdx != 1) begin
				for (int c = 0; c < 4; c++) begin
					a0 = blk_byte(t_ak, 4 * c);
					a1 = blk_byte(t_ak, 4 * c + 1);
					a2 = blk_byte(t_ak, 4 * c + 2);
					a3 = blk_byte(t_ak, 4 * c + 3);
					x2a = xtime(a0); x4a = xtime(x2a); x8a = xtime(x4a);
					x2b = xtime(a1); x4b = xtime(x2b); x8b = xtime(x4b);
					x2c = xtime(a2); x4c = xtime(x2c); x8c = xtime(x4c);
					x2d = xtime(a3); x4d = xtime(x2d); x8d = xtime(x4d);
					m0 = (x8a ^ x4a ^ x2a) ^ (x8b ^ x2b ^ a1) ^ (x8c ^ x4c ^ a2)
						^ (x8d ^ a3);
					m1 = (x8a ^ a0) ^ (x8b ^ x4b ^ x2b) ^ (x8c ^ x2c ^ a2)
						^ (x8d ^ x4d ^ a3);
					m2 = (x8a ^ x4a ^ a0) ^ (x8b ^ a1) ^ (x8c ^ x4c ^ x2c)
						^ (x8d ^ x2d ^ a3);
					m3 = (x8a ^ x2a ^ a0) ^ (x8b ^ x4b ^ a1) ^ (x8c ^ a2)
						^ (x8d ^ x4d ^ x2d);
					t_mc[127 - 32 * c -: 32] = {m0, m1, m2, m3};
				end
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++) begin
					src = 4 * ((c - r + 4) & 3) + r;
					t_isr[127 - 8 * (4 * c + r) -: 8] = blk_byte(t_mc, src);
				end
			for (int j = 0; j < 16; j++) t_isb[127 - 8 * j -: 8] = ISBOX[blk_byte(t_isr, j)];
			st_nx = t_isb ^ key_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		state_out <= st_nx;
		key_out <= key_nx;
	end

endmodule

### sim/aes128_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 cipher checker
// Watches the block, cipher key and direction channels, computes the expected
// ciphertext or plaintext of every accepted block and compares it with done.
// ----------------------------------------------------------------------------
module aes128_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [63:0] text_hi,
	input  logic [63:0] text_lo,
	input  logic [63:0] key_hi,
	input  logic [63:0] key_lo,
	input  logic        done,
	input  logic [63:0] result_hi,
	input  logic [63:0] result_lo,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	output int          errors,
	output int          pending
);

	logic         dir_model;
	logic [127:0] blocks_due [$];

	// GF(2^8) arithmetic, polynomial 0x11b
	function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[0])
				p ^= a;
			a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
			b = b >> 1;
		end
		return p;
	endfunction

	function automatic logic [7:0] gf_recip(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] base;
		int e;
		r = 8'h01;
		base = a;
		e = 254;
		while (e != 0) begin
			if (e & 1)
				r = gf_mult(r, base);
			base = gf_mult(base, base);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	function automatic logic [7:0] sub_byte(input logic [7:0] a);
		logic [7:0] b;
		b = gf_recip(a);
		return b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_sub_byte(input logic [7:0] y);
		return gf_recip(rot8(y, 1) ^ rot8(y, 3) ^ rot8(y, 6) ^ 8'h05);
	endfunction

	// whole cipher or inverse cipher for one block
	function automatic logic [127:0] aes_transform(input logic decrypt, input logic [127:0] blk,
			input logic [127:0] key);
		logic [7:0]   s [16];
		logic [7:0]   t [16];
		logic [7:0]   w [44][4];
		logic [7:0]   tmp [4];
		logic [7:0]   rc [10];
		logic [7:0]   a [4];
		logic [7:0]   m [4];
		logic [7:0]   v;
		logic [127:0] res;
		int           rd;
		rc[0] = 8'h01;
		for (int i = 1; i < 10; i++)
			rc[i] = rc[i-1][7] ? ((rc[i-1] << 1) ^ 8'h1b) : (rc[i-1] << 1);
		for (int n = 0; n < 16; n++)
			s[n] = blk[127 - 8 * n -: 8];
		// key schedule, forwards from the cipher key or backwards from the last round key
		if (!decrypt) begin
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					w[i][j] = key[127 - 8 * (4 * i + j) -: 8];
			for (int i = 4; i < 44; i++) begin
				if ((i & 3) == 0) begin
					for (int j = 0; j < 4; j++)
						tmp[j] = sub_byte(w[i-1][(j + 1) & 3]);
					tmp[0] ^= rc[i / 4 - 1];
					for (int j = 0; j < 4; j++)
						w[i][j] = w[i-4][j] ^ tmp[j];
				end else begin
					for (int j = 0; j < 4; j++)
						w[i][j] = w[i-4][j] ^ w[i-1][j];
				end
			end
		end else begin
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					w[40 + i][j] = key[127 - 8 * (4 * i + j) -: 8];
			for (int i = 39; i >= 0; i--) begin
				if ((i & 3) == 0) begin
					for (int j = 0; j < 4; j++)
						tmp[j] = sub_byte(w[i+3][(j + 1) & 3]);
					tmp[0] ^= rc[i / 4];
					for (int j = 0; j < 4; j++)
						w[i][j] = w[i+4][j] ^ tmp[j];
				end else begin
					for (int j = 0; j < 4; j++)
						w[i][j] = w[i+4][j] ^ w[i+3][j];
				end
			end
		end
		if (decrypt) begin
			m = '{8'd14, 8'd11, 8'd13, 8'd9};
		end else begin
			m = '{8'd2, 8'd3, 8'd1, 8'd1};
		end
		if (!decrypt) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					s[4 * c + r] ^= w[c][r];
		end
		for (int step = 1; step <= 10; step++) begin
			rd = decrypt ? 11 - step : step;
			if (decrypt) begin
				// add key, inverse mix, inverse shift, inverse substitution
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						s[4 * c + r] ^= w[4 * rd + c][r];
			end else begin
				for (int n = 0; n < 16; n++)
					s[n] = sub_byte(s[n]);
				t = s;
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						s[4 * c + r] = t[4 * ((c + r) & 3) + r];
			end
			if (rd != 10) begin
				for (int c = 0; c < 4; c++) begin
					for (int k = 0; k < 4; k++)
						a[k] = s[4 * c + k];
					for (int r = 0; r < 4; r++) begin
						v = 8'h00;
						for (int k = 0; k < 4; k++)
							v ^= gf_mult(m[(k - r + 4) & 3], a[k]);
						s[4 * c + r] = v;
					end
				end
			end
			if (decrypt) begin
				t = s;
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						s[4 * c + r] = t[4 * ((c - r + 4) & 3) + r];
				for (int n = 0; n < 16; n++)
					s[n] = inv_sub_byte(s[n]);
			end else begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						s[4 * c + r] ^= w[4 * rd + c][r];
			end
		end
		if (decrypt) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					s[4 * c + r] ^= w[c][r];
		end
		for (int n = 0; n < 16; n++)
			res[127 - 8 * n -: 8] = s[n];
		return res;
	endfunction

	assign pending = blocks_due.size();

	// track direction, predict on each accepted beat, compare each done beat
	always @(posedge clk or negedge arst_n) begin
		logic [127:0] due;
		if (!arst_n) begin
			dir_model <= 1'b0;
			errors = 0;
			blocks_due.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				dir_model <= cfg_data;
			if (start && !busy)
				blocks_due.push_back(aes_transform(dir_model, {text_hi, text_lo},
					{key_hi, key_lo}));
			if (done) begin
				if (blocks_due.size() == 0) begin
					$error("result beat with none expected: %h %h", result_hi, result_lo);
					errors++;
				end else begin
					due = blocks_due.pop_front();
					if (result_hi !== due[127:64]) begin
						$error("result_hi: expected %h, got %h", due[127:64], result_hi);
						errors++;
					end
					if (result_lo !== due[63:0]) begin
						$error("result_lo: expected %h, got %h", due[63:0], result_lo);
						errors++;
					end
				end
			end
		end
	end

endmodule

### sim/tb_aes128_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Known vectors, key and text extremes in both directions, then random blocks
// over several direction phases, random start gaps in all but the last; checker compares.
// ----------------------------------------------------------------------------
module tb_aes128_block_cipher;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] text_hi;
	logic [63:0] text_lo;
	logic [63:0] key_hi;
	logic [63:0] key_lo;
	logic        done;
	logic [63:0] result_hi;
	logic [63:0] result_lo;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	int          errors;
	int          pending;
	bit          gaps_on;

	aes128_block_cipher dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.text_hi(text_hi), .text_lo(text_lo), .key_hi(key_hi), .key_lo(key_lo),
		.done(done), .result_hi(result_hi), .result_lo(result_lo),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	aes128_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.text_hi(text_hi), .text_lo(text_lo), .key_hi(key_hi), .key_lo(key_lo),
		.done(done), .result_hi(result_hi), .result_lo(result_lo),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// one block beat, then an optional burst of idle cycles
	task automatic send_block(input logic [63:0] th, input logic [63:0] tl,
			input logic [63:0] kh, input logic [63:0] kl);
		start   <= 1'b1;
		text_hi <= th;
		text_lo <= tl;
		key_hi  <= kh;
		key_lo  <= kl;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19))
				@(posedge clk);
		end
	endtask

	// direction write once the pipeline has drained
	task automatic set_direction(input logic d);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_blocks(input int count);
		logic [63:0] kh;
		logic [63:0] kl;
		kh = rand64();
		kl = rand64();
		for (int n = 0; n < count; n++) begin
			// keys are often reused across a run of blocks
			if ($urandom_range(0, 2) == 0) begin
				kh = rand64();
				kl = rand64();
			end
			send_block(rand64(), rand64(), kh, kl);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		text_hi   = '0;
		text_lo   = '0;
		key_hi    = '0;
		key_lo    = '0;
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		gaps_on   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// encrypt: standard vector, all-zero and all-one text and key, then mixed extremes
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff,
			64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		send_block('0, '0, '0, '0);
		send_block('1, '1, '1, '1);
		send_block('0, '1, '1, '0);
		send_block(64'h8000000000000000, 64'h0000000000000001,
			64'h0000000000000001, 64'h8000000000000000);
		set_direction(1'b1);
		// decrypt with the last round key of the standard vector, and extremes
		send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a,
			64'h13111d7fe3944a17, 64'hf307a78b4d2b30c5);
		send_block('0, '0, '0, '0);
		send_block('1, '1, '1, '1);
		send_block('1, '0, '0, '1);
		send_block(64'h8000000000000000, 64'h0000000000000001,
			64'h0000000000000001, 64'h8000000000000000);

		// random phases, alternating direction; the last one without gaps
		gaps_on = 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			set_direction(ph[0]);
			if (ph == 5)
				gaps_on = 1'b0;
			random_blocks(100);
		end
		start <= 1'b0;

		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// run limit
	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
